// ===== hdl/cle_pkg.sv =====
`default_nettype none

package cle_pkg;

  // Node store geometry
  localparam int NODES  = 16;
  localparam int ADDR_W = $clog2(NODES);
  localparam int PTR_W  = $clog2(NODES + 1);
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(NODES);

  // Word fields
  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int LEN_W    = 5;

  localparam int IN_OPCODE_LSB = 0;
  localparam int IN_DATA_LSB   = IN_OPCODE_LSB + OPCODE_W;
  localparam int IN_POS_LSB    = IN_DATA_LSB + DATA_W;
  localparam int IN_BITS       = IN_POS_LSB + POS_W;
  localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_SLOT_LSB   = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_LEN_LSB    = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_BITS       = OUT_LEN_LSB + LEN_W;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_REAR   = 3'd1,
    OP_INS_POS    = 3'd2,
    OP_INS_SORTED = 3'd3,
    OP_DEL_FRONT  = 3'd4,
    OP_DEL_REAR   = 3'd5,
    OP_DEL_POS    = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  // Microcode
  localparam int UPC_W = 4;

  typedef enum logic [3:0] {
    A_NOP,
    A_LOAD,
    A_WALK,
    A_SWALK,
    A_ALLOC,
    A_LINK,
    A_UNLINK,
    A_FREE,
    A_ERR,
    A_FULL,
    A_EMIT
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOACC,
    C_ERR,
    C_SORTED,
    C_STEPS,
    C_DEL,
    C_FREE_NIL,
    C_SORT_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  localparam logic [UPC_W-1:0] U_FETCH  = 4'd0;
  localparam logic [UPC_W-1:0] U_WALK   = 4'd3;
  localparam logic [UPC_W-1:0] U_ALLOC  = 4'd5;
  localparam logic [UPC_W-1:0] U_SWALK  = 4'd7;
  localparam logic [UPC_W-1:0] U_UNLINK = 4'd9;
  localparam logic [UPC_W-1:0] U_ERR    = 4'd11;
  localparam logic [UPC_W-1:0] U_FULL   = 4'd12;
  localparam logic [UPC_W-1:0] U_EMIT   = 4'd13;

  // Jump to target when the condition holds, else fall through to the next step.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{A_LOAD,   C_NOACC,     U_FETCH};
      4'd1:    w = '{A_NOP,    C_ERR,       U_ERR};
      4'd2:    w = '{A_NOP,    C_SORTED,    U_SWALK};
      4'd3:    w = '{A_WALK,   C_STEPS,     U_WALK};
      4'd4:    w = '{A_NOP,    C_DEL,       U_UNLINK};
      4'd5:    w = '{A_ALLOC,  C_FREE_NIL,  U_FULL};
      4'd6:    w = '{A_LINK,   C_ALWAYS,    U_EMIT};
      4'd7:    w = '{A_SWALK,  C_SORT_MORE, U_SWALK};
      4'd8:    w = '{A_NOP,    C_ALWAYS,    U_ALLOC};
      4'd9:    w = '{A_UNLINK, C_NEVER,     U_FETCH};
      4'd10:   w = '{A_FREE,   C_ALWAYS,    U_EMIT};
      4'd11:   w = '{A_ERR,    C_ALWAYS,    U_EMIT};
      4'd12:   w = '{A_FULL,   C_NEVER,     U_FETCH};
      4'd13:   w = '{A_EMIT,   C_OUT_BUSY,  U_EMIT};
      default: w = '{A_NOP,    C_ALWAYS,    U_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cursor_linked_list_engine.sv =====
`default_nettype none

// Singly linked list of signed bytes kept in a 16-node store with a free list
// threaded through the unused nodes. Each input word is one command (insert
// front/rear/position/descending-sorted, delete front/rear/position) and gives
// exactly one output word: status, slot allocated or freed, and list length.
// A command refused for a delete on an empty list, a position out of range
// or an unused opcode is refused before any walk. The walk reads one node
// per cycle from the node store. Rear and positional inserts walk up to 16
// links, rear and positional deletes up to 15, and a sorted insert up to 16.
// A new command is taken only after the previous one has placed its result
// in the output register; that result may still be waiting for out_tready.
module cursor_linked_list_engine (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [2:0] opcode, [10:3] data, [15:11] position
  input  wire logic [cle_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [1:0] status, [5:2] slot, [10:6] list_length, [15:11] zero
  output logic [cle_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int PTR_W  = cle_pkg::PTR_W;
  localparam int ADDR_W = cle_pkg::ADDR_W;

  // Sequencer
  logic [cle_pkg::UPC_W-1:0] pc_r, pc_nxt;
  cle_pkg::ucode_t           uw;
  logic                      cond_true;

  // Command and walk registers
  cle_pkg::opcode_t             op_r, op_nxt;
  logic signed [cle_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                         err_r, err_nxt;
  logic [PTR_W-1:0]             steps_r, steps_nxt;
  logic [PTR_W-1:0]             cur_r, cur_nxt;
  logic [PTR_W-1:0]             prev_r, prev_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  cle_pkg::status_t             status_r, status_nxt;

  // List state
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [PTR_W-1:0]             free_r, free_nxt;
  logic [PTR_W-1:0]             count_r, count_nxt;
  logic [PTR_W-1:0]             node_link_r  [cle_pkg::NODES];
  logic signed [cle_pkg::DATA_W-1:0] node_value_r [cle_pkg::NODES];

  // Store ports
  logic [ADDR_W-1:0]            rd_addr;
  logic [PTR_W-1:0]             link_rd;
  logic signed [cle_pkg::DATA_W-1:0] value_rd;
  logic                         link_we, value_we;
  logic [ADDR_W-1:0]            link_wa, value_wa;
  logic [PTR_W-1:0]             link_wd;
  logic signed [cle_pkg::DATA_W-1:0] value_wd;

  // Output register
  logic                         out_valid_r;
  cle_pkg::status_t             out_status_r;
  logic [cle_pkg::SLOT_W-1:0]   out_slot_r;
  logic [cle_pkg::LEN_W-1:0]    out_len_r;
  logic                         out_load;
  logic                         out_busy;

  // Input word fields
  cle_pkg::opcode_t             in_opcode;
  logic signed [cle_pkg::DATA_W-1:0] in_data;
  logic [cle_pkg::POS_W-1:0]    in_position;
  logic                         in_acc;
  logic                         in_err;
  logic [PTR_W-1:0]             in_steps;

  logic                         free_nil;
  logic                         prev_nil;
  logic                         sort_more;
  logic                         op_is_del;

  assign in_opcode   = cle_pkg::opcode_t'(in_tdata[cle_pkg::IN_OPCODE_LSB +: cle_pkg::OPCODE_W]);
  assign in_data     = in_tdata[cle_pkg::IN_DATA_LSB +: cle_pkg::DATA_W];
  assign in_position = in_tdata[cle_pkg::IN_POS_LSB +: cle_pkg::POS_W];

  assign uw        = cle_pkg::ucode_rom(pc_r);
  assign in_tready = (pc_r == cle_pkg::U_FETCH);
  assign in_acc    = in_tvalid && in_tready;

  assign rd_addr  = (uw.act == cle_pkg::A_ALLOC) ? free_r[ADDR_W-1:0] : cur_r[ADDR_W-1:0];
  assign link_rd  = node_link_r[rd_addr];
  assign value_rd = node_value_r[cur_r[ADDR_W-1:0]];

  assign free_nil  = (free_r == cle_pkg::NIL_PTR);
  assign prev_nil  = (prev_r == cle_pkg::NIL_PTR);
  assign sort_more = (cur_r != cle_pkg::NIL_PTR) && (data_r < value_rd);
  assign op_is_del = (op_r == cle_pkg::OP_DEL_FRONT) || (op_r == cle_pkg::OP_DEL_REAR) ||
                     (op_r == cle_pkg::OP_DEL_POS);
  assign out_busy  = out_valid_r && !out_tready;

  // Refusal check and walk length, decided as the word is taken
  always_comb begin
    in_err   = 1'b0;
    in_steps = '0;
    unique case (in_opcode) inside
      cle_pkg::OP_INS_FRONT, cle_pkg::OP_INS_SORTED, cle_pkg::OP_DEL_FRONT: begin
        in_err = (in_opcode == cle_pkg::OP_DEL_FRONT) && (count_r == '0);
      end
      cle_pkg::OP_INS_REAR: begin
        in_steps = count_r;
      end
      cle_pkg::OP_INS_POS: begin
        in_err   = int'(in_position) > int'(count_r);
        in_steps = PTR_W'(in_position);
      end
      cle_pkg::OP_DEL_REAR: begin
        in_err   = (count_r == '0);
        in_steps = count_r - PTR_W'(1);
      end
      cle_pkg::OP_DEL_POS: begin
        in_err   = int'(in_position) >= int'(count_r);
        in_steps = PTR_W'(in_position);
      end
      default: begin
        in_err = 1'b1;
      end
    endcase
  end

  // Jump condition
  always_comb begin
    unique case (uw.cond)
      cle_pkg::C_NEVER:     cond_true = 1'b0;
      cle_pkg::C_ALWAYS:    cond_true = 1'b1;
      cle_pkg::C_NOACC:     cond_true = !in_acc;
      cle_pkg::C_ERR:       cond_true = err_r;
      cle_pkg::C_SORTED:    cond_true = (op_r == cle_pkg::OP_INS_SORTED);
      cle_pkg::C_STEPS:     cond_true = (steps_r != '0);
      cle_pkg::C_DEL:       cond_true = op_is_del;
      cle_pkg::C_FREE_NIL:  cond_true = free_nil;
      cle_pkg::C_SORT_MORE: cond_true = sort_more;
      cle_pkg::C_OUT_BUSY:  cond_true = out_busy;
      default:              cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = cond_true ? uw.target : pc_r + cle_pkg::UPC_W'(1);
  end

  // Datapath driven by the control word
  always_comb begin
    op_nxt     = op_r;
    data_nxt   = data_r;
    err_nxt    = err_r;
    steps_nxt  = steps_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    head_nxt   = head_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    link_we    = 1'b0;
    link_wa    = '0;
    link_wd    = '0;
    value_we   = 1'b0;
    value_wa   = '0;
    value_wd   = '0;
    out_load   = 1'b0;
    unique case (uw.act)
      cle_pkg::A_LOAD: begin
        if (in_acc) begin
          op_nxt    = in_opcode;
          data_nxt  = in_data;
          err_nxt   = in_err;
          steps_nxt = in_steps;
          cur_nxt   = head_r;
          prev_nxt  = cle_pkg::NIL_PTR;
        end
      end
      cle_pkg::A_WALK: begin
        if (steps_r != '0) begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rd;
          steps_nxt = steps_r - PTR_W'(1);
        end
      end
      cle_pkg::A_SWALK: begin
        if (sort_more) begin
          prev_nxt = cur_r;
          cur_nxt  = link_rd;
        end
      end
      cle_pkg::A_ALLOC: begin
        // pop the free list and fill the new node in front of cur
        if (!free_nil) begin
          idx_nxt  = free_r[ADDR_W-1:0];
          free_nxt = link_rd;
          link_we  = 1'b1;
          link_wa  = free_r[ADDR_W-1:0];
          link_wd  = cur_r;
          value_we = 1'b1;
          value_wa = free_r[ADDR_W-1:0];
          value_wd = data_r;
        end
      end
      cle_pkg::A_LINK: begin
        if (prev_nil) begin
          head_nxt = PTR_W'(idx_r);
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[ADDR_W-1:0];
          link_wd = PTR_W'(idx_r);
        end
        count_nxt  = count_r + PTR_W'(1);
        status_nxt = cle_pkg::ST_DONE;
      end
      cle_pkg::A_UNLINK: begin
        if (prev_nil) begin
          head_nxt = link_rd;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[ADDR_W-1:0];
          link_wd = link_rd;
        end
      end
      cle_pkg::A_FREE: begin
        // push the removed node onto the free list, value cleared
        link_we    = 1'b1;
        link_wa    = cur_r[ADDR_W-1:0];
        link_wd    = free_r;
        value_we   = 1'b1;
        value_wa   = cur_r[ADDR_W-1:0];
        value_wd   = '0;
        free_nxt   = cur_r;
        idx_nxt    = cur_r[ADDR_W-1:0];
        count_nxt  = count_r - PTR_W'(1);
        status_nxt = cle_pkg::ST_DONE;
      end
      cle_pkg::A_ERR: begin
        status_nxt = cle_pkg::ST_REFUSED;
      end
      cle_pkg::A_FULL: begin
        status_nxt = cle_pkg::ST_FULL;
      end
      cle_pkg::A_EMIT: begin
        out_load = !out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= cle_pkg::U_FETCH;
      head_r      <= cle_pkg::NIL_PTR;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < cle_pkg::NODES; i++) begin
        node_link_r[i]  <= (i + 1 < cle_pkg::NODES) ? PTR_W'(i + 1) : cle_pkg::NIL_PTR;
        node_value_r[i] <= '0;
      end
    end else begin
      pc_r    <= pc_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      if (link_we) begin
        node_link_r[link_wa] <= link_wd;
      end
      if (value_we) begin
        node_value_r[value_wa] <= value_wd;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    data_r   <= data_nxt;
    err_r    <= err_nxt;
    steps_r  <= steps_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_slot_r   <= (status_r == cle_pkg::ST_DONE) ? cle_pkg::SLOT_W'(idx_r) : '0;
      out_len_r    <= cle_pkg::LEN_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cle_pkg::OUT_TDATA_W'({out_len_r, out_slot_r, out_status_r});

endmodule

`default_nettype wire

// ===== hdl/cle_checker.sv =====
`default_nettype none

module cle_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [cle_pkg::IN_TDATA_W-1:0]   in_tdata,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [cle_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [cle_pkg::STATUS_W-1:0] st;
  logic [cle_pkg::SLOT_W-1:0]   slot;
  logic [cle_pkg::LEN_W-1:0]    len;

  assign st   = out_tdata[cle_pkg::OUT_STATUS_LSB +: cle_pkg::STATUS_W];
  assign slot = out_tdata[cle_pkg::OUT_SLOT_LSB +: cle_pkg::SLOT_W];
  assign len  = out_tdata[cle_pkg::OUT_LEN_LSB +: cle_pkg::LEN_W];

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The engine takes no command while it is busy with one: ready drops after a take.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while previous one in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == cle_pkg::ST_DONE) || (st == cle_pkg::ST_FULL) ||
                   (st == cle_pkg::ST_REFUSED))
    else $error("unknown status code");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st != cle_pkg::ST_DONE) |-> (slot == '0))
    else $error("refused command reports a slot");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(len) <= cle_pkg::NODES))
    else $error("list length beyond store size");

endmodule

bind cursor_linked_list_engine cle_checker u_cle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== dv/tb_cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps

module tb_cursor_linked_list_engine;

  localparam int NODES          = cle_pkg::NODES;
  localparam int PTR_W          = cle_pkg::PTR_W;
  localparam int ADDR_W         = cle_pkg::ADDR_W;
  localparam int OPCODE_W       = cle_pkg::OPCODE_W;
  localparam int DATA_W         = cle_pkg::DATA_W;
  localparam int POS_W          = cle_pkg::POS_W;
  localparam int STATUS_W       = cle_pkg::STATUS_W;
  localparam int SLOT_W         = cle_pkg::SLOT_W;
  localparam int LEN_W          = cle_pkg::LEN_W;
  localparam int IN_TDATA_W     = cle_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W    = cle_pkg::OUT_TDATA_W;
  localparam int OUT_STATUS_LSB = cle_pkg::OUT_STATUS_LSB;
  localparam int OUT_SLOT_LSB   = cle_pkg::OUT_SLOT_LSB;
  localparam int OUT_LEN_LSB    = cle_pkg::OUT_LEN_LSB;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam logic [PTR_W-1:0]    NIL       = cle_pkg::NIL_PTR;
  localparam int RANDOM_WORDS = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    cle_pkg::status_t    status;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    len;
  } reply_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [DATA_W-1:0]   data;
    logic [POS_W-1:0]    pos;
    bit                  fixed;
    reply_t              want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow of the node store and list pointers
  logic signed [DATA_W-1:0] node_val [NODES];
  logic [PTR_W-1:0]         node_next [NODES];
  logic [PTR_W-1:0]         list_top;
  logic [PTR_W-1:0]         free_top;
  int                       list_len;

  reply_t reply_q [$];
  reply_t got_reply;
  int     errors = 0;
  int     idle_cycles = 0;

  cursor_linked_list_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_list_shadow();
    for (int i = 0; i < NODES; i++) begin
      node_val[i]  = '0;
      node_next[i] = (i + 1 < NODES) ? PTR_W'(i + 1) : NIL;
    end
    list_top = NIL;
    free_top = '0;
    list_len = 0;
  endtask

  function automatic logic [PTR_W-1:0] node_at_index(int k);
    logic [PTR_W-1:0] cur;
    cur = list_top;
    for (int i = 0; i < k && i < NODES && cur != NIL; i++)
      cur = node_next[cur[ADDR_W-1:0]];
    return cur;
  endfunction

  // Apply one command to the shadow list and return the word it should produce
  function automatic reply_t apply_list_cmd(logic [OPCODE_W-1:0] op,
                                            logic signed [DATA_W-1:0] d,
                                            logic [POS_W-1:0] p);
    reply_t r;
    logic [PTR_W-1:0] prev;
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] slot;
    int k;
    r.status = cle_pkg::ST_REFUSED;
    r.slot = '0;
    r.len = LEN_W'(list_len);
    prev = NIL;
    if (op <= cle_pkg::OP_INS_SORTED) begin
      if (op == cle_pkg::OP_INS_REAR) begin
        prev = (list_len == 0) ? NIL : node_at_index(list_len - 1);
      end else if (op == cle_pkg::OP_INS_POS) begin
        if (p > list_len) return r;
        prev = (p == 0) ? NIL : node_at_index(p - 1);
      end else if (op == cle_pkg::OP_INS_SORTED) begin
        cur = list_top;
        for (int i = 0; i < NODES && cur != NIL && d < node_val[cur[ADDR_W-1:0]]; i++) begin
          prev = cur;
          cur = node_next[cur[ADDR_W-1:0]];
        end
      end
      if (free_top == NIL) begin
        r.status = cle_pkg::ST_FULL;
        return r;
      end
      slot = free_top;
      free_top = node_next[slot[ADDR_W-1:0]];
      node_val[slot[ADDR_W-1:0]] = d;
      if (prev == NIL) begin
        node_next[slot[ADDR_W-1:0]] = list_top;
        list_top = slot;
      end else begin
        node_next[slot[ADDR_W-1:0]] = node_next[prev[ADDR_W-1:0]];
        node_next[prev[ADDR_W-1:0]] = slot;
      end
      list_len++;
    end else if (op <= cle_pkg::OP_DEL_POS) begin
      if (list_len == 0) return r;
      if (op == cle_pkg::OP_DEL_FRONT) begin
        k = 0;
      end else if (op == cle_pkg::OP_DEL_REAR) begin
        k = list_len - 1;
      end else begin
        if (p >= list_len) return r;
        k = p;
      end
      prev = (k == 0) ? NIL : node_at_index(k - 1);
      slot = (k == 0) ? list_top : node_next[prev[ADDR_W-1:0]];
      if (prev == NIL) list_top = node_next[slot[ADDR_W-1:0]];
      else node_next[prev[ADDR_W-1:0]] = node_next[slot[ADDR_W-1:0]];
      // freed node goes back on top of the free list, cleared
      node_val[slot[ADDR_W-1:0]] = '0;
      node_next[slot[ADDR_W-1:0]] = free_top;
      free_top = slot;
      list_len--;
    end else begin
      return r;
    end
    r.status = cle_pkg::ST_DONE;
    r.slot = slot[SLOT_W-1:0];
    r.len = LEN_W'(list_len);
    return r;
  endfunction

  function automatic dir_row_t make_row(logic [OPCODE_W-1:0] op, int d, int p,
                                        bit fixed = 1'b0,
                                        cle_pkg::status_t st = cle_pkg::ST_DONE,
                                        int slot = 0, int len = 0);
    dir_row_t row;
    row.op = op;
    row.data = DATA_W'(d);
    row.pos = POS_W'(p);
    row.fixed = fixed;
    row.want.status = st;
    row.want.slot = SLOT_W'(slot);
    row.want.len = LEN_W'(len);
    return row;
  endfunction

  // Present one word, hold it until accepted, then record its expected reply
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] d,
                           logic [POS_W-1:0] p, bit fixed, reply_t want);
    reply_t r;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {p, d, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_list_cmd(op, d, p);
    reply_q.push_back(fixed ? want : r);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_replies_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: switches at random between four stall patterns
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 99) < 75);
      2: out_tready <= (rx_cycle % 5 == 0);
      default: out_tready <= ($urandom_range(0, 99) < 30);
    endcase
  end

  assign got_reply.status = cle_pkg::status_t'(out_tdata[OUT_STATUS_LSB +: STATUS_W]);
  assign got_reply.slot   = out_tdata[OUT_SLOT_LSB +: SLOT_W];
  assign got_reply.len    = out_tdata[OUT_LEN_LSB +: LEN_W];

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected word: status %0d slot %0d list_length %0d",
               got_reply.status, got_reply.slot, got_reply.len);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (got_reply.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_reply.status);
          errors++;
        end
        if (got_reply.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got_reply.slot);
          errors++;
        end
        if (got_reply.len !== want.len) begin
          $error("list_length: expected %0d, got %0d", want.len, got_reply.len);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    int burst_left;
    int phase_left;
    int grow_pct;
    int pause_at;
    logic [OPCODE_W-1:0] op;
    logic [DATA_W-1:0] d;
    logic [POS_W-1:0] p;

    clear_list_shadow();

    // Empty list: every delete, an out-of-range insert and an unused opcode are refused
    rows.push_back(make_row(cle_pkg::OP_DEL_FRONT, 0, 0, 1'b1, cle_pkg::ST_REFUSED, 0, 0));
    rows.push_back(make_row(cle_pkg::OP_DEL_REAR, 0, 0, 1'b1, cle_pkg::ST_REFUSED, 0, 0));
    rows.push_back(make_row(cle_pkg::OP_DEL_POS, 0, 0, 1'b1, cle_pkg::ST_REFUSED, 0, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, 5, 1, 1'b1, cle_pkg::ST_REFUSED, 0, 0));
    rows.push_back(make_row(OP_UNUSED, -1, 31, 1'b1, cle_pkg::ST_REFUSED, 0, 0));
    // Fill the store with every insert flavor
    rows.push_back(make_row(cle_pkg::OP_INS_FRONT, 127, 0, 1'b1, cle_pkg::ST_DONE, 0, 1));
    rows.push_back(make_row(cle_pkg::OP_INS_REAR, -128, 0, 1'b1, cle_pkg::ST_DONE, 1, 2));
    rows.push_back(make_row(cle_pkg::OP_INS_SORTED, 0, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, -1, 3));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, 1, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_SORTED, -128, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_SORTED, 127, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_REAR, 5, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_FRONT, -5, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, 'h55, 5));
    rows.push_back(make_row(cle_pkg::OP_INS_SORTED, 100, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, -100, 11));
    rows.push_back(make_row(cle_pkg::OP_INS_FRONT, 42, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_SORTED, -1, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_REAR, 0, 0));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, 7, 15));
    // Store full, range checks at full length, then a delete of each kind
    rows.push_back(make_row(cle_pkg::OP_INS_SORTED, 3, 0, 1'b1, cle_pkg::ST_FULL, 0, 16));
    rows.push_back(make_row(cle_pkg::OP_INS_POS, 3, 31, 1'b1, cle_pkg::ST_REFUSED, 0, 16));
    rows.push_back(make_row(cle_pkg::OP_DEL_POS, 0, 16, 1'b1, cle_pkg::ST_REFUSED, 0, 16));
    rows.push_back(make_row(cle_pkg::OP_DEL_POS, 0, 15));
    rows.push_back(make_row(cle_pkg::OP_DEL_FRONT, 0, 0));
    rows.push_back(make_row(cle_pkg::OP_DEL_REAR, 0, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      row = rows[i];
      send_word(row.op, row.data, row.pos, row.fixed, row.want);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 4));
    end
    wait_replies_drained();

    burst_left = 0;
    phase_left = 0;
    grow_pct = 50;
    pause_at = $urandom_range(50, RANDOM_WORDS - 50);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Phases that lean toward growing or shrinking reach full and empty often
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: grow_pct = 85;
          1: grow_pct = 15;
          default: grow_pct = 50;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < 2) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < grow_pct) op = OPCODE_W'($urandom_range(0, 3));
      else op = OPCODE_W'($urandom_range(4, 6));
      case ($urandom_range(0, 3))
        0: d = $urandom_range(0, 1) ? 8'h80 : 8'h7f;
        1: d = DATA_W'($urandom_range(0, 6)) - 8'd3;
        default: d = DATA_W'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 99) < 85) p = POS_W'($urandom_range(0, list_len));
      else p = POS_W'($urandom_range(0, 31));

      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 10));
      end
      burst_left--;
      if (n == pause_at || n % 300 == 299) wait_replies_drained();
      send_word(op, d, p, 1'b0, '0);
    end

    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
